### sv/gsp_pkg.sv
// gsp_pkg: shared types, widths and constants of the gas sensor ppm converter
// used by gsp_div, gsp_log2 and gas_sensor_ppm_converter
`default_nettype none
package gsp_pkg;

    localparam int ADC_W      = 10;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int RES_W      = 32;
    localparam int SUM_W      = 38;
    localparam int CNT_W      = 6;
    localparam int CONC_W     = 16;
    localparam int DIV_NUM_W  = 40;
    localparam int DIV_DEN_W  = 16;
    localparam int DIV_CNT_W  = 6;
    localparam int LOG_IN_W   = 32;
    localparam int LOG_INT_W  = 5;
    localparam int LOG_FRAC_W = 16;
    localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
    localparam int PROD_W     = 38;
    localparam int E_W        = 42;
    localparam int D_W        = 24;

    localparam int CAL_SAMPLES_DEF  = 50;
    localparam int MEAS_SAMPLES_DEF = 5;

    localparam logic [ADC_W-1:0]   ADC_FULL    = 10'd1023;
    localparam logic [RES_W-1:0]   RES_SAT     = 32'hFFFF_FFFF;
    localparam logic [CONC_W-1:0]  CONC_MAX    = 16'hFFFF;
    localparam logic signed [15:0] LOG10_2_Q16 = 16'sd19728;
    localparam int                 E_LIMIT     = 16 * 19728;

    localparam logic [CFG_W-1:0] LOAD_RES_RST  = 16'd1280;
    localparam logic [CFG_W-1:0] CAF_RST       = 16'd2516;
    localparam logic [CFG_W-1:0] LPG_X_RST     = 16'd9421;
    localparam logic [CFG_W-1:0] LPG_Y_RST     = 16'd860;
    localparam logic [CFG_W-1:0] LPG_SLOPE_RST = 16'hF87B;
    localparam logic [CFG_W-1:0] SMK_X_RST     = 16'd9421;
    localparam logic [CFG_W-1:0] SMK_Y_RST     = 16'd2171;
    localparam logic [CFG_W-1:0] SMK_SLOPE_RST = 16'hF8F6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOAD_RES, CFG_CAF, CFG_LPG_X, CFG_LPG_Y, CFG_LPG_SLOPE,
        CFG_SMK_X, CFG_SMK_Y, CFG_SMK_SLOPE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        STS_OK, STS_ZERO_ADC, STS_NO_CAL, STS_SAT
    } t_status;

    typedef enum logic {
        KIND_CAL, KIND_MEAS
    } t_kind;

    typedef enum logic [1:0] {
        GAS_LPG, GAS_SMOKE
    } t_gas;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SDIV, ST_ACC, ST_AVG, ST_RODIV, ST_CFIN, ST_LRS, ST_LRO,
        ST_LR, ST_DST, ST_CDIV, ST_ECHK, ST_BS, ST_BLOG, ST_BCMP, ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        LG_IDLE, LG_NORM, LG_SQ
    } t_log_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic                start;
        logic [LOG_IN_W-1:0] val;
    } t_log_req;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] lg;
    } t_log_rsp;

endpackage
`default_nettype wire

### sv/gsp_div.sv
// gsp_div: bit-serial restoring divider, one quotient bit per cycle
// depends on gsp_pkg
`default_nettype none
module gsp_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gsp_pkg::t_div_req i_req,
    output gsp_pkg::t_div_rsp      o_rsp
);
    localparam int NW = gsp_pkg::DIV_NUM_W;
    localparam int DW = gsp_pkg::DIV_DEN_W;

    logic                               r_busy, n_busy;
    logic                               r_done, n_done;
    logic [gsp_pkg::DIV_CNT_W-1:0]      r_cnt, n_cnt;
    logic [DW-1:0]                      r_rem, n_rem;
    logic [DW-1:0]                      r_den, n_den;
    logic [NW-1:0]                      r_quo, n_quo;
    logic [DW:0]                        w_trial, w_diff;
    logic                               w_ge;

    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_den  = i_req.den;
            n_quo  = i_req.num;
        end else if (r_busy) begin
            n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            n_quo = {r_quo[NW-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == gsp_pkg::DIV_CNT_W'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
`default_nettype wire

### sv/gsp_log2.sv
// gsp_log2: serial log2 in Q16, normalize one bit per cycle then one squaring per bit
// depends on gsp_pkg
`default_nettype none
module gsp_log2 (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gsp_pkg::t_log_req i_req,
    output gsp_pkg::t_log_rsp      o_rsp
);
    localparam int MW = gsp_pkg::LOG_IN_W;
    localparam int FW = gsp_pkg::LOG_FRAC_W;

    gsp_pkg::t_log_state            r_state, n_state;
    logic                           r_done, n_done;
    logic [MW-1:0]                  r_m, n_m;
    logic [gsp_pkg::LOG_INT_W-1:0]  r_n, n_n;
    logic [FW-1:0]                  r_frac, n_frac;
    logic [3:0]                     r_it, n_it;
    logic [2*MW-3:0]                w_prod;
    logic [MW-1:0]                  w_sq;

    assign w_prod = r_m[MW-2:0] * r_m[MW-2:0];
    assign w_sq   = w_prod[2*MW-3:MW-2];

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_m     = r_m;
        n_n     = r_n;
        n_frac  = r_frac;
        n_it    = r_it;
        unique case (r_state)
            gsp_pkg::LG_IDLE: begin
                if (i_req.start) begin
                    n_m     = i_req.val;
                    n_n     = '1;
                    n_state = gsp_pkg::LG_NORM;
                end
            end
            gsp_pkg::LG_NORM: begin
                if (r_m[MW-1]) begin
                    n_m     = {1'b0, r_m[MW-1:1]};
                    n_it    = '0;
                    n_state = gsp_pkg::LG_SQ;
                end else begin
                    n_m = {r_m[MW-2:0], 1'b0};
                    n_n = r_n - 1'b1;
                end
            end
            gsp_pkg::LG_SQ: begin
                n_m    = w_sq[MW-1] ? {1'b0, w_sq[MW-1:1]} : w_sq;
                n_frac = {r_frac[FW-2:0], w_sq[MW-1]};
                n_it   = r_it + 1'b1;
                if (r_it == 4'(FW - 1)) begin
                    n_done  = 1'b1;
                    n_state = gsp_pkg::LG_IDLE;
                end
            end
            default: n_state = gsp_pkg::LG_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gsp_pkg::LG_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_n    <= n_n;
        r_frac <= n_frac;
        r_it   <= n_it;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.lg   = {r_n, r_frac};

endmodule
`default_nettype wire

### sv/gas_sensor_ppm_converter.sv
// gas_sensor_ppm_converter: top level, window sums, calibration and log-log curve sequencer
// depends on gsp_pkg, gsp_div, gsp_log2
//
//  channel   group    dir  transaction holds
//  input     s_axis   in   tdata adc_sample, tuser mode and gas_select
//  result    m_axis   out  tdata resistance, concentration, status; tuser result_kind
//  config    i_cfg_*  in   register index and 16-bit value, one write per cycle
//
// each nonzero sample is converted to a resistance by the 40-step serial divider
// a window end runs the average divide, then the Ro divide in calibration, or in
// measurement two serial logs, one divide and a binary search of up to 16 steps
// with one log per step
// synchronous active-low reset; a finished result waits in the output register
// while the next sample is taken, and the block stalls only when a new result is ready before the last is taken
`default_nettype none
module gas_sensor_ppm_converter #(
    parameter int CALIBRATION_SAMPLES = gsp_pkg::CAL_SAMPLES_DEF,
    parameter int MEASURE_SAMPLES     = gsp_pkg::MEAS_SAMPLES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [9:0] adc_sample
    input  wire logic [2:0]  s_axis_tuser,   // [0] mode, [2:1] gas_select
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // [31:0] resistance, [47:32] concentration,
                                             // [49:48] status
    output logic [0:0]       m_axis_tuser,   // [0] result_kind
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);
    localparam int RW = gsp_pkg::RES_W;
    localparam int NW = gsp_pkg::DIV_NUM_W;
    localparam int CW = gsp_pkg::CNT_W;

    logic [15:0]        r_load_res, r_caf;
    logic signed [15:0] r_lpg_x, r_lpg_y, r_lpg_slope, r_smk_x, r_smk_y, r_smk_slope;

    gsp_pkg::t_state             r_state, n_state;
    logic [1:0]                  r_gas, n_gas;
    logic                        r_mode, n_mode;
    logic                        r_wmode, n_wmode;
    logic [gsp_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [CW-1:0]               r_cnt, n_cnt;
    gsp_pkg::t_status            r_werr, n_werr;
    logic [RW-1:0]               r_samp, n_samp;
    logic [RW-1:0]               r_avg, n_avg;
    logic [RW-1:0]               r_ro, n_ro;
    logic                        r_cal, n_cal;
    logic                        r_sat, n_sat;
    logic [15:0]                 r_conc, n_conc;
    logic [gsp_pkg::LOG_W-1:0]   r_lrs, n_lrs;
    logic signed [gsp_pkg::PROD_W-1:0] r_prod, n_prod;
    logic signed [gsp_pkg::E_W-1:0]    r_e, n_e;
    logic signed [gsp_pkg::D_W-1:0]    r_d, n_d;
    logic                        r_neg, n_neg;
    logic [15:0]                 r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic                        r_out_valid, n_out_valid;
    logic                        r_out_kind, n_out_kind;
    logic [RW-1:0]               r_out_res, n_out_res;
    logic [15:0]                 r_out_conc, n_out_conc;
    gsp_pkg::t_status            r_out_status, n_out_status;

    gsp_pkg::t_div_req w_div_req;
    gsp_pkg::t_div_rsp w_div_rsp;
    gsp_pkg::t_log_req w_log_req;
    gsp_pkg::t_log_rsp w_log_rsp;

    logic [CW-1:0]               w_size;
    logic signed [15:0]          w_x, w_y, w_slope;
    logic signed [21:0]          w_mul_a;
    logic signed [gsp_pkg::PROD_W-1:0] w_mul_p, w_adj;
    logic signed [21:0]          w_lr;
    logic [25:0]                 w_rl_prod;
    logic [gsp_pkg::D_W-1:0]     w_dmag;
    logic [15:0]                 w_smag;
    logic [gsp_pkg::E_W-1:0]     w_qx;
    logic signed [gsp_pkg::E_W-1:0] w_x16;
    logic [16:0]                 w_mid_sum;
    logic [CW:0]                 w_cnt_inc;
    logic [gsp_pkg::SUM_W-1:0]   w_sum_new;

    gsp_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    gsp_log2 u_log (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_log_req),
        .o_rsp  (w_log_rsp)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_res  <= gsp_pkg::LOAD_RES_RST;
            r_caf       <= gsp_pkg::CAF_RST;
            r_lpg_x     <= gsp_pkg::LPG_X_RST;
            r_lpg_y     <= gsp_pkg::LPG_Y_RST;
            r_lpg_slope <= gsp_pkg::LPG_SLOPE_RST;
            r_smk_x     <= gsp_pkg::SMK_X_RST;
            r_smk_y     <= gsp_pkg::SMK_Y_RST;
            r_smk_slope <= gsp_pkg::SMK_SLOPE_RST;
        end else if (i_cfg_we) begin
            unique case (gsp_pkg::t_cfg_idx'(i_cfg_addr))
                gsp_pkg::CFG_LOAD_RES:  r_load_res  <= i_cfg_wdata;
                gsp_pkg::CFG_CAF:       r_caf       <= i_cfg_wdata;
                gsp_pkg::CFG_LPG_X:     r_lpg_x     <= i_cfg_wdata;
                gsp_pkg::CFG_LPG_Y:     r_lpg_y     <= i_cfg_wdata;
                gsp_pkg::CFG_LPG_SLOPE: r_lpg_slope <= i_cfg_wdata;
                gsp_pkg::CFG_SMK_X:     r_smk_x     <= i_cfg_wdata;
                gsp_pkg::CFG_SMK_Y:     r_smk_y     <= i_cfg_wdata;
                gsp_pkg::CFG_SMK_SLOPE: r_smk_slope <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_size  = r_wmode ? CW'(MEASURE_SAMPLES) : CW'(CALIBRATION_SAMPLES);
    assign w_x     = (r_gas == gsp_pkg::GAS_SMOKE) ? r_smk_x     : r_lpg_x;
    assign w_y     = (r_gas == gsp_pkg::GAS_SMOKE) ? r_smk_y     : r_lpg_y;
    assign w_slope = (r_gas == gsp_pkg::GAS_SMOKE) ? r_smk_slope : r_lpg_slope;

    assign w_mul_a = (r_state == gsp_pkg::ST_LRO)
                   ? $signed({1'b0, r_lrs}) - $signed({1'b0, w_log_rsp.lg})
                   : $signed({1'b0, w_log_rsp.lg});
    assign w_mul_p = w_mul_a * gsp_pkg::LOG10_2_Q16;

    // truncation toward zero of the product over 65536
    assign w_adj   = r_prod + (r_prod[gsp_pkg::PROD_W-1] ? 38'sd65535 : 38'sd0);
    assign w_lr    = w_adj[gsp_pkg::PROD_W-1:16];

    assign w_rl_prod = r_load_res * (gsp_pkg::ADC_FULL - s_axis_tdata[9:0]);
    assign w_dmag    = r_d[gsp_pkg::D_W-1] ? gsp_pkg::D_W'(-r_d) : gsp_pkg::D_W'(r_d);
    assign w_smag    = w_slope[15] ? 16'(-w_slope) : 16'(w_slope);
    assign w_qx      = {2'b00, w_div_rsp.quo};
    assign w_x16     = {{22{w_x[15]}}, w_x, 4'b0000};
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + 17'd1;
    assign w_cnt_inc = {1'b0, r_cnt} + 1'b1;
    assign w_sum_new = r_sum + gsp_pkg::SUM_W'(r_samp);

    always_comb begin
        n_state      = r_state;
        n_gas        = r_gas;
        n_mode       = r_mode;
        n_wmode      = r_wmode;
        n_sum        = r_sum;
        n_cnt        = r_cnt;
        n_werr       = r_werr;
        n_samp       = r_samp;
        n_avg        = r_avg;
        n_ro         = r_ro;
        n_cal        = r_cal;
        n_sat        = r_sat;
        n_conc       = r_conc;
        n_lrs        = r_lrs;
        n_prod       = r_prod;
        n_e          = r_e;
        n_d          = r_d;
        n_neg        = r_neg;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_kind   = r_out_kind;
        n_out_res    = r_out_res;
        n_out_conc   = r_out_conc;
        n_out_status = r_out_status;
        w_div_req    = '0;
        w_log_req    = '0;
        s_axis_tready = 1'b0;

        unique case (r_state)
            gsp_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_mode  = s_axis_tuser[0];
                    n_gas   = s_axis_tuser[2:1];
                    n_wmode = s_axis_tuser[0];
                    // mode change drops the partial window
                    if (r_cnt != '0 && s_axis_tuser[0] != r_wmode) begin
                        n_sum  = '0;
                        n_cnt  = '0;
                        n_werr = gsp_pkg::STS_OK;
                    end
                    if (s_axis_tdata[9:0] == '0) begin
                        n_samp  = gsp_pkg::RES_SAT;
                        n_werr  = gsp_pkg::STS_ZERO_ADC;
                        n_state = gsp_pkg::ST_ACC;
                    end else begin
                        w_div_req.start = 1'b1;
                        w_div_req.num   = NW'({w_rl_prod, 8'h00});
                        w_div_req.den   = 16'(s_axis_tdata[9:0]);
                        n_state         = gsp_pkg::ST_SDIV;
                    end
                end
            end
            gsp_pkg::ST_SDIV: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quo[NW-1:RW] != '0) begin
                        n_samp = gsp_pkg::RES_SAT;
                        if (r_werr == gsp_pkg::STS_OK) begin
                            n_werr = gsp_pkg::STS_SAT;
                        end
                    end else begin
                        n_samp = w_div_rsp.quo[RW-1:0];
                    end
                    n_state = gsp_pkg::ST_ACC;
                end
            end
            gsp_pkg::ST_ACC: begin
                n_sum = w_sum_new;
                n_cnt = w_cnt_inc[CW-1:0];
                if (w_cnt_inc >= {1'b0, w_size}) begin
                    w_div_req.start = 1'b1;
                    w_div_req.num   = NW'(w_sum_new);
                    w_div_req.den   = 16'(w_size);
                    n_state         = gsp_pkg::ST_AVG;
                end else begin
                    n_state = gsp_pkg::ST_IDLE;
                end
            end
            gsp_pkg::ST_AVG: begin
                if (w_div_rsp.done) begin
                    n_avg = w_div_rsp.quo[RW-1:0];
                    n_sat = 1'b0;
                    n_conc = '0;
                    if (r_mode == gsp_pkg::KIND_CAL) begin
                        if (r_caf == '0) begin
                            n_samp  = gsp_pkg::RES_SAT;
                            n_sat   = 1'b1;
                            n_state = gsp_pkg::ST_CFIN;
                        end else begin
                            w_div_req.start = 1'b1;
                            w_div_req.num   = {w_div_rsp.quo[RW-1:0], 8'h00};
                            w_div_req.den   = r_caf;
                            n_state         = gsp_pkg::ST_RODIV;
                        end
                    end else if (r_gas[1]) begin
                        n_state = gsp_pkg::ST_OUT;
                    end else if (!r_cal) begin
                        n_conc  = gsp_pkg::CONC_MAX;
                        n_state = gsp_pkg::ST_OUT;
                    end else if (w_slope == '0) begin
                        n_conc  = gsp_pkg::CONC_MAX;
                        n_sat   = 1'b1;
                        n_state = gsp_pkg::ST_OUT;
                    end else if (w_div_rsp.quo[RW-1:0] == '0) begin
                        if (w_slope[15]) begin
                            n_conc = gsp_pkg::CONC_MAX;
                            n_sat  = 1'b1;
                        end
                        n_state = gsp_pkg::ST_OUT;
                    end else begin
                        w_log_req.start = 1'b1;
                        w_log_req.val   = w_div_rsp.quo[RW-1:0];
                        n_state         = gsp_pkg::ST_LRS;
                    end
                end
            end
            gsp_pkg::ST_RODIV: begin
                if (w_div_rsp.done) begin
                    if (w_div_rsp.quo[NW-1:RW] != '0) begin
                        n_samp = gsp_pkg::RES_SAT;
                        n_sat  = 1'b1;
                    end else begin
                        n_samp = w_div_rsp.quo[RW-1:0];
                    end
                    n_state = gsp_pkg::ST_CFIN;
                end
            end
            gsp_pkg::ST_CFIN: begin
                n_ro    = r_samp;
                n_cal   = (r_samp != '0);
                n_state = gsp_pkg::ST_OUT;
            end
            gsp_pkg::ST_LRS: begin
                if (w_log_rsp.done) begin
                    n_lrs           = w_log_rsp.lg;
                    w_log_req.start = 1'b1;
                    w_log_req.val   = r_ro;
                    n_state         = gsp_pkg::ST_LRO;
                end
            end
            gsp_pkg::ST_LRO: begin
                if (w_log_rsp.done) begin
                    n_prod  = w_mul_p;
                    n_state = gsp_pkg::ST_LR;
                end
            end
            gsp_pkg::ST_LR: begin
                n_d     = {{2{w_lr[21]}}, w_lr} - {{4{w_y[15]}}, w_y, 4'b0000};
                n_state = gsp_pkg::ST_DST;
            end
            gsp_pkg::ST_DST: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = {4'h0, w_dmag, 12'h000};
                w_div_req.den   = w_smag;
                n_neg           = r_d[gsp_pkg::D_W-1] ^ w_slope[15];
                n_state         = gsp_pkg::ST_CDIV;
            end
            gsp_pkg::ST_CDIV: begin
                if (w_div_rsp.done) begin
                    n_e     = (r_neg ? -$signed(w_qx) : $signed(w_qx)) + w_x16;
                    n_state = gsp_pkg::ST_ECHK;
                end
            end
            gsp_pkg::ST_ECHK: begin
                if (r_e[gsp_pkg::E_W-1]) begin
                    n_conc  = '0;
                    n_state = gsp_pkg::ST_OUT;
                end else if (r_e >= gsp_pkg::E_W'(gsp_pkg::E_LIMIT)) begin
                    n_conc  = gsp_pkg::CONC_MAX;
                    n_sat   = 1'b1;
                    n_state = gsp_pkg::ST_OUT;
                end else begin
                    n_lo    = 16'd1;
                    n_hi    = gsp_pkg::CONC_MAX;
                    n_state = gsp_pkg::ST_BS;
                end
            end
            gsp_pkg::ST_BS: begin
                if (r_lo < r_hi) begin
                    n_mid           = w_mid_sum[16:1];
                    w_log_req.start = 1'b1;
                    w_log_req.val   = gsp_pkg::LOG_IN_W'(w_mid_sum[16:1]);
                    n_state         = gsp_pkg::ST_BLOG;
                end else begin
                    n_conc  = r_lo;
                    n_state = gsp_pkg::ST_OUT;
                end
            end
            gsp_pkg::ST_BLOG: begin
                if (w_log_rsp.done) begin
                    n_prod  = w_mul_p;
                    n_state = gsp_pkg::ST_BCMP;
                end
            end
            gsp_pkg::ST_BCMP: begin
                if (r_prod[gsp_pkg::PROD_W-1:16] <= r_e[21:0]) begin
                    n_lo = r_mid;
                end else begin
                    n_hi = r_mid - 1'b1;
                end
                n_state = gsp_pkg::ST_BS;
            end
            gsp_pkg::ST_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_mode;
                    n_out_conc  = r_conc;
                    if (r_mode == gsp_pkg::KIND_CAL) begin
                        n_out_res = r_ro;
                        if (r_werr == gsp_pkg::STS_ZERO_ADC) begin
                            n_out_status = gsp_pkg::STS_ZERO_ADC;
                        end else if (r_werr == gsp_pkg::STS_SAT || r_sat) begin
                            n_out_status = gsp_pkg::STS_SAT;
                        end else if (!r_cal) begin
                            n_out_status = gsp_pkg::STS_NO_CAL;
                        end else begin
                            n_out_status = gsp_pkg::STS_OK;
                        end
                    end else begin
                        n_out_res = r_avg;
                        if (r_werr == gsp_pkg::STS_ZERO_ADC) begin
                            n_out_status = gsp_pkg::STS_ZERO_ADC;
                        end else if (!r_cal) begin
                            n_out_status = gsp_pkg::STS_NO_CAL;
                        end else if (r_werr == gsp_pkg::STS_SAT || r_sat) begin
                            n_out_status = gsp_pkg::STS_SAT;
                        end else begin
                            n_out_status = gsp_pkg::STS_OK;
                        end
                    end
                    n_sum   = '0;
                    n_cnt   = '0;
                    n_werr  = gsp_pkg::STS_OK;
                    n_state = gsp_pkg::ST_IDLE;
                end
            end
            default: n_state = gsp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gsp_pkg::ST_IDLE;
            r_wmode     <= 1'b0;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_werr      <= gsp_pkg::STS_OK;
            r_ro        <= '0;
            r_cal       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wmode     <= n_wmode;
            r_sum       <= n_sum;
            r_cnt       <= n_cnt;
            r_werr      <= n_werr;
            r_ro        <= n_ro;
            r_cal       <= n_cal;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gas        <= n_gas;
        r_mode       <= n_mode;
        r_samp       <= n_samp;
        r_avg        <= n_avg;
        r_sat        <= n_sat;
        r_conc       <= n_conc;
        r_lrs        <= n_lrs;
        r_prod       <= n_prod;
        r_e          <= n_e;
        r_d          <= n_d;
        r_neg        <= n_neg;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_out_kind   <= n_out_kind;
        r_out_res    <= n_out_res;
        r_out_conc   <= n_out_conc;
        r_out_status <= n_out_status;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_out_status, r_out_conc, r_out_res};
    assign m_axis_tuser  = r_out_kind;

`ifndef SYNTHESIS
    a_cnt_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gsp_pkg::ST_IDLE) |-> (r_cnt < w_size))
        else $error("window count reached size while idle");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == gsp_pkg::ST_SDIV || r_state == gsp_pkg::ST_AVG ||
                            r_state == gsp_pkg::ST_RODIV || r_state == gsp_pkg::ST_CDIV))
        else $error("divider finished with no sequencer waiting");

    a_log_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_log_rsp.done |-> (r_state == gsp_pkg::ST_LRS || r_state == gsp_pkg::ST_LRO ||
                            r_state == gsp_pkg::ST_BLOG))
        else $error("log unit finished with no sequencer waiting");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gsp_pkg::ST_OUT && n_state == gsp_pkg::ST_IDLE) |=> m_axis_tvalid)
        else $error("window finished without a result");
`endif

endmodule
`default_nettype wire
